FILE: hdl/cgbt_pkg.sv
// shared constants, types and the triangle table of the cut glyph box triangulator
package cgbt_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CELL_W  = 10;
    localparam int CUT_W   = 16;
    localparam int BID_W   = 8;
    localparam int COORD_W = 32;
    localparam int PITCH_W = 31;
    localparam int FACE_W  = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int NUM_AXES = 3;
    localparam int NUM_TRIS = 12;
    localparam int STAGES   = 5;

    localparam logic [FACE_W-1:0] FACE_LAST  = 3'd5;
    localparam logic [3:0]        LAST_PHASE = 4'(NUM_TRIS - 1);

    // register indexes, byte address bits [4:2]
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_PITCH_X  = 3'd3;
    localparam logic [2:0] REG_PITCH_Y  = 3'd4;
    localparam logic [2:0] REG_PITCH_Z  = 3'd5;

    localparam logic signed [COORD_W-1:0] ORIGIN_RST = '0;
    localparam logic [PITCH_W-1:0]        PITCH_RST  = 31'd65536;

    // load enables of the five lane stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
    } t_stage_ctl;

    typedef struct packed {
        logic [2:0][NUM_AXES-1:0][COORD_W-1:0] vtx;
        logic [2:0]                            normal_dir;
        logic [BID_W-1:0]                      tri_boundary_id;
        logic                                  last_triangle;
    } t_tri;

    // corners of triangle k, packed as {v2, v1, v0}
    function automatic logic [8:0] tri_corners(input logic [3:0] k);
        logic [8:0] c;
        case (k)
            4'd0:    c = {3'd3, 3'd7, 3'd0};
            4'd1:    c = {3'd7, 3'd4, 3'd0};
            4'd2:    c = {3'd6, 3'd2, 3'd1};
            4'd3:    c = {3'd5, 3'd6, 3'd1};
            4'd4:    c = {3'd5, 3'd1, 3'd0};
            4'd5:    c = {3'd4, 3'd5, 3'd0};
            4'd6:    c = {3'd6, 3'd7, 3'd3};
            4'd7:    c = {3'd2, 3'd6, 3'd3};
            4'd8:    c = {3'd1, 3'd3, 3'd0};
            4'd9:    c = {3'd1, 3'd2, 3'd3};
            4'd10:   c = {3'd7, 3'd5, 3'd4};
            4'd11:   c = {3'd7, 3'd6, 3'd5};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/cgbt_ifs.sv
// valid/ready channels for glyph requests and triangle words
interface cgbt_glyph_if;
    logic                         valid;
    logic                         ready;
    logic [cgbt_pkg::CELL_W-1:0]  cell_x;
    logic [cgbt_pkg::CELL_W-1:0]  cell_y;
    logic [cgbt_pkg::CELL_W-1:0]  cell_z;
    logic [cgbt_pkg::FACE_W-1:0]  face;
    logic [cgbt_pkg::CUT_W-1:0]   cut_offset;
    logic [cgbt_pkg::BID_W-1:0]   boundary_id;

    modport source (output valid, cell_x, cell_y, cell_z, face, cut_offset, boundary_id,
                    input ready);
    modport sink (input valid, cell_x, cell_y, cell_z, face, cut_offset, boundary_id,
                  output ready);
endinterface

interface cgbt_tri_if;
    logic                                valid;
    logic                                ready;
    logic signed [cgbt_pkg::COORD_W-1:0] v0_x;
    logic signed [cgbt_pkg::COORD_W-1:0] v0_y;
    logic signed [cgbt_pkg::COORD_W-1:0] v0_z;
    logic signed [cgbt_pkg::COORD_W-1:0] v1_x;
    logic signed [cgbt_pkg::COORD_W-1:0] v1_y;
    logic signed [cgbt_pkg::COORD_W-1:0] v1_z;
    logic signed [cgbt_pkg::COORD_W-1:0] v2_x;
    logic signed [cgbt_pkg::COORD_W-1:0] v2_y;
    logic signed [cgbt_pkg::COORD_W-1:0] v2_z;
    logic [2:0]                          normal_dir;
    logic [cgbt_pkg::BID_W-1:0]          tri_boundary_id;
    logic                                last_triangle;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    normal_dir, tri_boundary_id, last_triangle, input ready);
    modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  normal_dir, tri_boundary_id, last_triangle, output ready);
endinterface

FILE: hdl/cgbt_regs.sv
// apb register file: grid origin and pitch per axis
module cgbt_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [cgbt_pkg::ADDR_W-1:0]         i_paddr,
    input  logic [cgbt_pkg::DATA_W-1:0]         i_pwdata,
    output logic [cgbt_pkg::DATA_W-1:0]         o_prdata,
    output logic signed [cgbt_pkg::COORD_W-1:0] o_org [cgbt_pkg::NUM_AXES],
    output logic [cgbt_pkg::PITCH_W-1:0]        o_pitch [cgbt_pkg::NUM_AXES]
);

    logic signed [cgbt_pkg::COORD_W-1:0] r_org [cgbt_pkg::NUM_AXES];
    logic [cgbt_pkg::PITCH_W-1:0]        r_pitch [cgbt_pkg::NUM_AXES];
    logic                                wr;
    logic [2:0]                          sel;

    assign wr  = i_psel && i_penable && i_pwrite;
    assign sel = i_paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < cgbt_pkg::NUM_AXES; a++) begin
                r_org[a]   <= cgbt_pkg::ORIGIN_RST;
                r_pitch[a] <= cgbt_pkg::PITCH_RST;
            end
        end else if (wr) begin
            case (sel)
                cgbt_pkg::REG_ORIGIN_X: r_org[0]   <= i_pwdata;
                cgbt_pkg::REG_ORIGIN_Y: r_org[1]   <= i_pwdata;
                cgbt_pkg::REG_ORIGIN_Z: r_org[2]   <= i_pwdata;
                cgbt_pkg::REG_PITCH_X:  r_pitch[0] <= i_pwdata[cgbt_pkg::PITCH_W-1:0];
                cgbt_pkg::REG_PITCH_Y:  r_pitch[1] <= i_pwdata[cgbt_pkg::PITCH_W-1:0];
                cgbt_pkg::REG_PITCH_Z:  r_pitch[2] <= i_pwdata[cgbt_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            cgbt_pkg::REG_ORIGIN_X: o_prdata = r_org[0];
            cgbt_pkg::REG_ORIGIN_Y: o_prdata = r_org[1];
            cgbt_pkg::REG_ORIGIN_Z: o_prdata = r_org[2];
            cgbt_pkg::REG_PITCH_X:  o_prdata = {1'b0, r_pitch[0]};
            cgbt_pkg::REG_PITCH_Y:  o_prdata = {1'b0, r_pitch[1]};
            cgbt_pkg::REG_PITCH_Z:  o_prdata = {1'b0, r_pitch[2]};
            default:                o_prdata = '0;
        endcase
    end

    assign o_org   = r_org;
    assign o_pitch = r_pitch;

endmodule

FILE: hdl/cgbt_lane.sv
// five-stage pipeline for one box coordinate: position, magnitude, product, round, cap
module cgbt_lane #(
    parameter int INDEX_BITS = cgbt_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = cgbt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  cgbt_pkg::t_stage_ctl                i_ctl,
    input  logic [INDEX_BITS-1:0]               i_idx,
    input  logic signed [FRAC_BITS+1:0]         i_off,
    input  logic signed [cgbt_pkg::COORD_W-1:0] i_org,
    input  logic [cgbt_pkg::PITCH_W-1:0]        i_pitch,
    output logic signed [cgbt_pkg::COORD_W-1:0] o_coord
);

    localparam int TW  = INDEX_BITS + FRAC_BITS + 2;
    localparam int AW  = TW - 1;
    localparam int AP  = (AW > 33) ? AW : 33;
    localparam int HW  = AP - 32;
    localparam int P1W = HW + cgbt_pkg::PITCH_W;
    localparam int RW  = 64 - FRAC_BITS;
    localparam int SW  = RW + 1;
    localparam logic signed [TW-1:0] HALF_T = TW'(64'd1 << (FRAC_BITS - 1));
    localparam logic [63:0]          HALF_R = 64'd1 << (FRAC_BITS - 1);
    localparam logic [33:0]          CAP    = 34'h2_0000_0000;
    localparam logic [SW-1:0]        CAP_S  = SW'(CAP);

    logic signed [TW-1:0] r_t, n_t, t_neg;
    logic [AW-1:0]        mag;
    logic [AP-1:0]        r_a;
    logic                 r_neg2, r_neg3, r_neg4, r_neg5;
    logic [62:0]          r_p0, n_p0;
    logic [P1W-1:0]       r_p1, n_p1;
    logic [63:0]          sum0;
    logic [RW-1:0]        r_rnd;
    logic [FRAC_BITS-1:0] r_p1lo;
    logic                 r_ovf;
    logic [SW-1:0]        sum1;
    logic [33:0]          r_m, n_m;
    logic signed [34:0]   sorg, sm, v;

    // cell corner at index - 0.5, plus the vertex offset
    assign n_t   = $signed({2'b00, i_idx, {FRAC_BITS{1'b0}}}) - HALF_T + TW'(i_off);
    assign t_neg = -r_t;
    assign mag   = r_t[TW-1] ? t_neg[AW-1:0] : r_t[AW-1:0];

    assign n_p0 = r_a[31:0] * i_pitch;
    assign n_p1 = r_a[AP-1:32] * i_pitch;

    assign sum0 = {1'b0, r_p0} + HALF_R;

    assign sum1 = SW'({r_p1lo, {(32 - FRAC_BITS){1'b0}}}) + SW'(r_rnd);
    assign n_m  = (r_ovf || (sum1 > CAP_S)) ? CAP : sum1[33:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_t <= n_t;
        end
        if (i_ctl.ld2) begin
            r_a    <= AP'(mag);
            r_neg2 <= r_t[TW-1];
        end
        if (i_ctl.ld3) begin
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_neg3 <= r_neg2;
        end
        if (i_ctl.ld4) begin
            r_rnd  <= sum0[63:FRAC_BITS];
            r_p1lo <= r_p1[FRAC_BITS-1:0];
            r_ovf  <= |r_p1[P1W-1:FRAC_BITS];
            r_neg4 <= r_neg3;
        end
        if (i_ctl.ld5) begin
            r_m    <= n_m;
            r_neg5 <= r_neg4;
        end
    end

    assign sorg = 35'(i_org);
    assign sm   = $signed({1'b0, r_m});
    assign v    = r_neg5 ? (sorg - sm) : (sorg + sm);

    always_comb begin
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            o_coord = v[31:0];
        end else if (v[34]) begin
            o_coord = 32'sh8000_0000;
        end else begin
            o_coord = 32'sh7FFF_FFFF;
        end
    end

endmodule

FILE: hdl/cgbt_emit.sv
// glyph holding register and triangle sequencer, one triangle word per cycle while the sink is ready
module cgbt_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [cgbt_pkg::COORD_W-1:0] i_coord [2*cgbt_pkg::NUM_AXES],
    input  logic [cgbt_pkg::BID_W-1:0]          i_bid,
    input  logic                                i_rdy,
    output logic                                o_take,
    output logic                                o_vld,
    output cgbt_pkg::t_tri                      o_tri
);

    logic                                r_busy;
    logic [3:0]                          r_phase;
    logic [cgbt_pkg::BID_W-1:0]          r_bid;
    logic signed [cgbt_pkg::COORD_W-1:0] r_coord [2*cgbt_pkg::NUM_AXES];
    logic                                last;
    logic [8:0]                          corners;
    logic [2:0]                          c;

    assign last   = (r_phase == cgbt_pkg::LAST_PHASE);
    assign o_take = !r_busy || (i_rdy && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
            r_bid   <= '0;
        end else if (o_take && i_vld) begin
            r_busy  <= 1'b1;
            r_phase <= '0;
            r_bid   <= i_bid;
        end else if (o_take) begin
            r_busy <= 1'b0;
        end else if (i_rdy) begin
            r_phase <= r_phase + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_vld) begin
            r_coord <= i_coord;
        end
    end

    assign corners = cgbt_pkg::tri_corners(r_phase);

    // corner bit 0 xor bit 1 selects high x, bit 1 high y, bit 2 high z
    always_comb begin
        o_tri = '0;
        c     = '0;
        for (int j = 0; j < 3; j++) begin
            c = corners[3*j +: 3];
            o_tri.vtx[j][0] = r_coord[{2'd0, c[0] ^ c[1]}];
            o_tri.vtx[j][1] = r_coord[{2'd1, c[1]}];
            o_tri.vtx[j][2] = r_coord[{2'd2, c[2]}];
        end
        o_tri.normal_dir      = r_phase[3:1];
        o_tri.tri_boundary_id = r_bid;
        o_tri.last_triangle   = last;
    end

    assign o_vld = r_busy;

endmodule

FILE: hdl/cut_glyph_box_triangulator.sv
// Cut glyph box triangulator top level. Each accepted glyph word (cell, face, cut
// distance, boundary id) yields twelve triangle words, one per cycle while the sink
// is ready. The six box coordinates run through six parallel five-stage lanes
// (position, magnitude, 32x31 products, rounding, cap) and land in the triangle
// sequencer. The input keeps taking glyphs into the lanes while the sequencer is
// still emitting, until all five lane stages hold a valid glyph. Faces 6 and 7 are
// taken and produce no triangles. Origin and pitch are to be written over APB only
// while the block is idle; the block itself does not enforce this.
module cut_glyph_box_triangulator #(
    parameter int INDEX_BITS = cgbt_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = cgbt_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cgbt_pkg::ADDR_W-1:0] paddr,
    input  logic [cgbt_pkg::DATA_W-1:0] pwdata,
    output logic [cgbt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    cgbt_glyph_if.sink                  i_glyph,
    cgbt_tri_if.source                  o_tri
);

    localparam int OW  = FRAC_BITS + 2;
    localparam int PW  = FRAC_BITS + cgbt_pkg::CUT_W;
    localparam int SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [OW-1:0] QUARTER = OW'(64'd1 << (FRAC_BITS - 2));
    localparam logic signed [OW-1:0] THICK   = OW'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);
    localparam int NA = cgbt_pkg::NUM_AXES;
    localparam int NS = cgbt_pkg::STAGES;

    logic signed [cgbt_pkg::COORD_W-1:0] org [NA];
    logic [cgbt_pkg::PITCH_W-1:0]        pitch [NA];
    logic [PW-1:0]                       cut_ext, cut_shift;
    logic signed [OW-1:0]                pos;
    logic signed [OW-1:0]                off_lo [NA];
    logic signed [OW-1:0]                off_hi [NA];
    logic [INDEX_BITS-1:0]               idx [NA];
    logic [NS:1]                         r_vld;
    logic [NS+1:1]                       en;
    logic [cgbt_pkg::BID_W-1:0]          r_bid [NS];
    logic                                in_vld;
    cgbt_pkg::t_stage_ctl                ctl;
    logic signed [cgbt_pkg::COORD_W-1:0] coord [2*NA];
    logic                                take;
    cgbt_pkg::t_tri                      tri_word;

    cgbt_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_org     (org),
        .o_pitch   (pitch)
    );

    assign pready = 1'b1;

    // cut distance brought from q0.16 to frac_bits fraction bits
    assign cut_ext   = PW'(i_glyph.cut_offset);
    assign cut_shift = (FRAC_BITS >= 16) ? (cut_ext << SHL) : (cut_ext >> SHR);
    assign pos       = $signed({2'b00, cut_shift[FRAC_BITS-1:0]});

    assign idx[0] = INDEX_BITS'({{INDEX_BITS{1'b0}}, i_glyph.cell_x});
    assign idx[1] = INDEX_BITS'({{INDEX_BITS{1'b0}}, i_glyph.cell_y});
    assign idx[2] = INDEX_BITS'({{INDEX_BITS{1'b0}}, i_glyph.cell_z});

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            if (i_glyph.face[2:1] == 2'(a)) begin
                if (!i_glyph.face[0]) begin
                    off_lo[a] = -pos;
                    off_hi[a] = THICK - pos;
                end else begin
                    off_lo[a] = pos - THICK;
                    off_hi[a] = pos;
                end
            end else begin
                off_lo[a] = -QUARTER;
                off_hi[a] = QUARTER;
            end
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[NS+1] = take;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_glyph.ready = en[1];
    assign in_vld = i_glyph.valid && en[1] && (i_glyph.face <= cgbt_pkg::FACE_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= in_vld;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_bid[0] <= i_glyph.boundary_id;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k+1]) begin
                r_bid[k] <= r_bid[k-1];
            end
        end
    end

    assign ctl.ld1 = en[1];
    assign ctl.ld2 = en[2];
    assign ctl.ld3 = en[3];
    assign ctl.ld4 = en[4];
    assign ctl.ld5 = en[5];

    for (genvar a = 0; a < NA; a++) begin : g_axis
        cgbt_lane #(
            .INDEX_BITS (INDEX_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lo (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_idx   (idx[a]),
            .i_off   (off_lo[a]),
            .i_org   (org[a]),
            .i_pitch (pitch[a]),
            .o_coord (coord[2*a])
        );
        cgbt_lane #(
            .INDEX_BITS (INDEX_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_hi (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_idx   (idx[a]),
            .i_off   (off_hi[a]),
            .i_org   (org[a]),
            .i_pitch (pitch[a]),
            .o_coord (coord[2*a+1])
        );
    end

    cgbt_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[NS]),
        .i_coord (coord),
        .i_bid   (r_bid[NS-1]),
        .i_rdy   (o_tri.ready),
        .o_take  (take),
        .o_vld   (o_tri.valid),
        .o_tri   (tri_word)
    );

    assign o_tri.v0_x            = tri_word.vtx[0][0];
    assign o_tri.v0_y            = tri_word.vtx[0][1];
    assign o_tri.v0_z            = tri_word.vtx[0][2];
    assign o_tri.v1_x            = tri_word.vtx[1][0];
    assign o_tri.v1_y            = tri_word.vtx[1][1];
    assign o_tri.v1_z            = tri_word.vtx[1][2];
    assign o_tri.v2_x            = tri_word.vtx[2][0];
    assign o_tri.v2_y            = tri_word.vtx[2][1];
    assign o_tri.v2_z            = tri_word.vtx[2][2];
    assign o_tri.normal_dir      = tri_word.normal_dir;
    assign o_tri.tri_boundary_id = tri_word.tri_boundary_id;
    assign o_tri.last_triangle   = tri_word.last_triangle;

endmodule

FILE: verif/cut_glyph_box_triangulator_tb.sv
// self-checking testbench for the cut glyph box triangulator: apb setup, glyph stream, triangle check
module cut_glyph_box_triangulator_tb;

    localparam int CELL_W   = cgbt_pkg::CELL_W;
    localparam int CUT_W    = cgbt_pkg::CUT_W;
    localparam int BID_W    = cgbt_pkg::BID_W;
    localparam int FACE_W   = cgbt_pkg::FACE_W;
    localparam int COORD_W  = cgbt_pkg::COORD_W;
    localparam int PITCH_W  = cgbt_pkg::PITCH_W;
    localparam int ADDR_W   = cgbt_pkg::ADDR_W;
    localparam int DATA_W   = cgbt_pkg::DATA_W;
    localparam int NUM_AXES = cgbt_pkg::NUM_AXES;
    localparam int NUM_TRIS = cgbt_pkg::NUM_TRIS;

    localparam longint ONE_CELL   = longint'(1) <<< cgbt_pkg::FRAC_BITS_DEF;
    localparam longint HALF_CELL  = ONE_CELL >>> 1;
    localparam longint QUARTER    = ONE_CELL >>> 2;
    localparam longint THICK      = (ONE_CELL + 10) / 20;
    localparam longint COORD_MAX  = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN  = -(longint'(1) <<< (COORD_W - 1));
    localparam longint SCALE_CAP  = longint'(1) <<< 33;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int NUM_PHASES     = 8;
    localparam int RANDOM_PER_PHASE = 40;
    localparam int MAX_PRINTED    = 100;
    localparam logic [CELL_W-1:0] CELL_TOP  = '1;
    localparam logic [CUT_W-1:0]  CUT_TOP   = '1;
    localparam logic [BID_W-1:0]  BID_TOP   = '1;
    localparam logic [FACE_W-1:0] FACE_TOP  = '1;

    // corners of triangle k at bits [9k +: 9], packed {v2, v1, v0}
    localparam bit [NUM_TRIS*9-1:0] BOX_TRI_CORNERS = {
        {3'd7, 3'd6, 3'd5}, {3'd7, 3'd5, 3'd4}, {3'd1, 3'd2, 3'd3}, {3'd1, 3'd3, 3'd0},
        {3'd2, 3'd6, 3'd3}, {3'd6, 3'd7, 3'd3}, {3'd4, 3'd5, 3'd0}, {3'd5, 3'd1, 3'd0},
        {3'd5, 3'd6, 3'd1}, {3'd6, 3'd2, 3'd1}, {3'd7, 3'd4, 3'd0}, {3'd3, 3'd7, 3'd0}
    };

    typedef struct packed {
        logic [NUM_AXES-1:0][CELL_W-1:0] cell_idx;
        logic [FACE_W-1:0]               face;
        logic [CUT_W-1:0]                cut;
        logic [BID_W-1:0]                bid;
    } t_glyph_req;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    cgbt_glyph_if glyph_bus();
    cgbt_tri_if   tri_bus();

    cut_glyph_box_triangulator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_glyph (glyph_bus),
        .o_tri   (tri_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic signed [COORD_W-1:0] grid_origin [NUM_AXES];
    logic [PITCH_W-1:0]        grid_pitch  [NUM_AXES];
    t_glyph_req       pending_glyphs [$];
    cgbt_pkg::t_tri   expected_tris  [$];
    int error_count    = 0;
    int cycle_count    = 0;
    int tri_count      = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // origin + (cell - 0.5 + off) * pitch, rounded half away from zero, saturated
    function automatic logic [COORD_W-1:0] axis_position(input logic signed [COORD_W-1:0] org,
                                                         input logic [PITCH_W-1:0] pitch,
                                                         input logic [CELL_W-1:0] cell_idx,
                                                         input longint off);
        longint pos;
        longint unsigned mag;
        longint unsigned scaled;
        longint coord;
        pos = longint'(cell_idx) * ONE_CELL - HALF_CELL + off;
        mag = (pos < 0) ? -pos : pos;
        scaled = (mag * 64'(pitch) + HALF_CELL) >> cgbt_pkg::FRAC_BITS_DEF;
        if (scaled > SCALE_CAP)
            scaled = SCALE_CAP;
        coord = longint'(org) + ((pos < 0) ? -longint'(scaled) : longint'(scaled));
        if (coord > COORD_MAX)
            coord = COORD_MAX;
        if (coord < COORD_MIN)
            coord = COORD_MIN;
        return coord[COORD_W-1:0];
    endfunction

    function automatic void predict_triangles(input t_glyph_req g);
        logic [COORD_W-1:0] span [NUM_AXES][2];
        longint lo;
        longint hi;
        longint cut_pos;
        logic [2:0] corner;
        cgbt_pkg::t_tri tri_word;
        if (g.face > cgbt_pkg::FACE_LAST)
            return;
        cut_pos = longint'(g.cut) <<< (cgbt_pkg::FRAC_BITS_DEF - CUT_W);
        for (int a = 0; a < NUM_AXES; a++) begin
            lo = -QUARTER;
            hi = QUARTER;
            if (a == int'(g.face >> 1)) begin
                if (!g.face[0]) begin
                    lo = -cut_pos;
                    hi = THICK - cut_pos;
                end else begin
                    lo = cut_pos - THICK;
                    hi = cut_pos;
                end
            end
            span[a][0] = axis_position(grid_origin[a], grid_pitch[a], g.cell_idx[a], lo);
            span[a][1] = axis_position(grid_origin[a], grid_pitch[a], g.cell_idx[a], hi);
        end
        for (int k = 0; k < NUM_TRIS; k++) begin
            for (int j = 0; j < 3; j++) begin
                corner = BOX_TRI_CORNERS[k*9 + j*3 +: 3];
                // x is high on corners 1 and 2 of each square
                tri_word.vtx[j][0] = span[0][corner[1] ^ corner[0]];
                tri_word.vtx[j][1] = span[1][corner[1]];
                tri_word.vtx[j][2] = span[2][corner[2]];
            end
            tri_word.normal_dir      = 3'(k >> 1);
            tri_word.tri_boundary_id = g.bid;
            tri_word.last_triangle   = (k == NUM_TRIS - 1);
            expected_tris.push_back(tri_word);
        end
    endfunction

    always @(posedge i_clk) begin : glyph_driver
        t_glyph_req taken;
        t_glyph_req next_req;
        if (!i_rst_n) begin
            glyph_bus.valid <= 1'b0;
        end else begin
            if (glyph_bus.valid && glyph_bus.ready) begin
                taken.cell_idx[0] = glyph_bus.cell_x;
                taken.cell_idx[1] = glyph_bus.cell_y;
                taken.cell_idx[2] = glyph_bus.cell_z;
                taken.face        = glyph_bus.face;
                taken.cut         = glyph_bus.cut_offset;
                taken.bid         = glyph_bus.boundary_id;
                predict_triangles(taken);
            end
            if (!glyph_bus.valid || glyph_bus.ready) begin
                if (pending_glyphs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_glyphs.pop_front();
                    glyph_bus.valid       <= 1'b1;
                    glyph_bus.cell_x      <= next_req.cell_idx[0];
                    glyph_bus.cell_y      <= next_req.cell_idx[1];
                    glyph_bus.cell_z      <= next_req.cell_idx[2];
                    glyph_bus.face        <= next_req.face;
                    glyph_bus.cut_offset  <= next_req.cut;
                    glyph_bus.boundary_id <= next_req.bid;
                end else begin
                    glyph_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            tri_bus.ready <= 1'b0;
        else
            tri_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : tri_monitor
        cgbt_pkg::t_tri got;
        cgbt_pkg::t_tri want;
        string axis_name [NUM_AXES];
        axis_name = '{"x", "y", "z"};
        if (i_rst_n && tri_bus.valid && tri_bus.ready) begin
            got.vtx[0] = {tri_bus.v0_z, tri_bus.v0_y, tri_bus.v0_x};
            got.vtx[1] = {tri_bus.v1_z, tri_bus.v1_y, tri_bus.v1_x};
            got.vtx[2] = {tri_bus.v2_z, tri_bus.v2_y, tri_bus.v2_x};
            got.normal_dir      = tri_bus.normal_dir;
            got.tri_boundary_id = tri_bus.tri_boundary_id;
            got.last_triangle   = tri_bus.last_triangle;
            if (expected_tris.size() == 0) begin
                report_mismatch($sformatf("triangle word %0d arrived with none expected",
                                          tri_count));
            end else begin
                want = expected_tris.pop_front();
                for (int j = 0; j < 3; j++)
                    for (int a = 0; a < NUM_AXES; a++)
                        if (got.vtx[j][a] !== want.vtx[j][a])
                            report_mismatch($sformatf("word %0d v%0d_%s: got %0d, expected %0d",
                                tri_count, j, axis_name[a], $signed(got.vtx[j][a]),
                                $signed(want.vtx[j][a])));
                if (got.normal_dir !== want.normal_dir)
                    report_mismatch($sformatf("word %0d normal_dir: got %0d, expected %0d",
                        tri_count, got.normal_dir, want.normal_dir));
                if (got.tri_boundary_id !== want.tri_boundary_id)
                    report_mismatch($sformatf("word %0d tri_boundary_id: got %0d, expected %0d",
                        tri_count, got.tri_boundary_id, want.tri_boundary_id));
                if (got.last_triangle !== want.last_triangle)
                    report_mismatch($sformatf("word %0d last_triangle: got %0b, expected %0b",
                        tri_count, got.last_triangle, want.last_triangle));
            end
            tri_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx <= cgbt_pkg::REG_ORIGIN_Z) begin
            grid_origin[idx[1:0]] = value;
            readback = value;
        end else begin
            grid_pitch[2'(idx - cgbt_pkg::REG_PITCH_X)] = value[PITCH_W-1:0];
            readback = {1'b0, value[PITCH_W-1:0]};
        end
        // read back through the same port
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== readback)
            report_mismatch($sformatf("register %0d read: got %h, expected %h",
                                      idx, prdata, readback));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid(input logic [DATA_W-1:0] ox, input logic [DATA_W-1:0] oy,
                            input logic [DATA_W-1:0] oz, input logic [DATA_W-1:0] px,
                            input logic [DATA_W-1:0] py, input logic [DATA_W-1:0] pz);
        write_reg(cgbt_pkg::REG_ORIGIN_X, ox);
        write_reg(cgbt_pkg::REG_ORIGIN_Y, oy);
        write_reg(cgbt_pkg::REG_ORIGIN_Z, oz);
        write_reg(cgbt_pkg::REG_PITCH_X, px);
        write_reg(cgbt_pkg::REG_PITCH_Y, py);
        write_reg(cgbt_pkg::REG_PITCH_Z, pz);
    endtask

    task automatic queue_glyph(input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy,
                               input logic [CELL_W-1:0] cz, input logic [FACE_W-1:0] face,
                               input logic [CUT_W-1:0] cut, input logic [BID_W-1:0] bid);
        t_glyph_req g;
        g.cell_idx[0] = cx;
        g.cell_idx[1] = cy;
        g.cell_idx[2] = cz;
        g.face        = face;
        g.cut         = cut;
        g.bid         = bid;
        pending_glyphs.push_back(g);
    endtask

    function automatic logic [CELL_W-1:0] pick_cell();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0)
            return '0;
        if (r == 1)
            return CELL_TOP;
        return CELL_W'($urandom_range(CELL_TOP));
    endfunction

    task automatic queue_random_glyph();
        logic [FACE_W-1:0] face;
        logic [CUT_W-1:0] cut;
        int unsigned r;
        // invalid faces now and then, mostly real glyphs
        if ($urandom_range(15) == 0)
            face = FACE_W'($urandom_range(FACE_TOP, cgbt_pkg::FACE_LAST + 1));
        else
            face = FACE_W'($urandom_range(cgbt_pkg::FACE_LAST));
        r = $urandom_range(9);
        if (r == 0)
            cut = '0;
        else if (r == 1)
            cut = CUT_TOP;
        else if (r == 2)
            cut = CUT_W'(THICK);
        else
            cut = CUT_W'($urandom);
        queue_glyph(pick_cell(), pick_cell(), pick_cell(), face, cut, BID_W'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_glyphs.size() != 0 || glyph_bus.valid || expected_tris.size() != 0)
            @(posedge i_clk);
        // glyphs on invalid faces leave nothing to wait for
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [DATA_W-1:0] ox;
        logic [DATA_W-1:0] oy;
        logic [DATA_W-1:0] oz;
        logic [DATA_W-1:0] px;
        logic [DATA_W-1:0] py;
        logic [DATA_W-1:0] pz;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        glyph_bus.valid       = 1'b0;
        glyph_bus.cell_x      = '0;
        glyph_bus.cell_y      = '0;
        glyph_bus.cell_z      = '0;
        glyph_bus.face        = '0;
        glyph_bus.cut_offset  = '0;
        glyph_bus.boundary_id = '0;
        tri_bus.ready         = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            grid_origin[a] = cgbt_pkg::ORIGIN_RST;
            grid_pitch[a]  = cgbt_pkg::PITCH_RST;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 28;
                stall_pct     = 69;
            end else if (ph < 6) begin
                send_idle_pct = 69;
                stall_pct     = 28;
            end else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            ox = cgbt_pkg::ORIGIN_RST;
            oy = cgbt_pkg::ORIGIN_RST;
            oz = cgbt_pkg::ORIGIN_RST;
            px = DATA_W'(cgbt_pkg::PITCH_RST);
            py = DATA_W'(cgbt_pkg::PITCH_RST);
            pz = DATA_W'(cgbt_pkg::PITCH_RST);
            case (ph)
                1: begin
                    ox = $urandom;
                    oy = $urandom;
                    oz = $urandom;
                    px = $urandom_range(1 << 18, 1);
                    py = $urandom_range(1 << 18, 1);
                    pz = $urandom_range(1 << 18, 1);
                end
                2: begin
                    // saturates high
                    ox = 32'h7fff_ffff;
                    oy = 32'h7fff_ffff;
                    oz = 32'h7fff_ffff;
                    px = 32'h7fff_ffff;
                    py = 32'h7fff_ffff;
                    pz = 32'h7fff_ffff;
                end
                3: begin
                    // saturates low
                    ox = 32'h8000_0000;
                    oy = 32'h8000_0000;
                    oz = 32'h8000_0000;
                    px = 32'h7fff_ffff;
                    py = 32'h7fff_ffff;
                    pz = 32'h7fff_ffff;
                end
                4: begin
                    // smallest pitch, and a zero pitch on y
                    ox = 32'h0000_0001;
                    px = 32'd1;
                    py = 32'd0;
                    pz = 32'd1;
                end
                5: begin
                    ox = $urandom;
                    oy = $urandom;
                    oz = $urandom;
                    px = $urandom;
                    py = $urandom;
                    pz = $urandom;
                end
                6: begin
                    ox = $urandom_range(1 << 24);
                    oy = -$urandom_range(1 << 24);
                    oz = $urandom_range(1 << 28);
                    px = $urandom_range(1 << 20, 1 << 12);
                    py = $urandom_range(1 << 20, 1 << 12);
                    pz = $urandom_range(1 << 20, 1 << 12);
                end
                default: ;
            endcase
            set_grid(ox, oy, oz, px, py, pz);

            if (ph == 0) begin
                for (int f = 0; f <= FACE_TOP; f++)
                    queue_glyph(pick_cell(), pick_cell(), pick_cell(), FACE_W'(f),
                                CUT_W'($urandom), BID_W'($urandom));
                queue_glyph('0, '0, '0, '0, '0, '0);
                queue_glyph(CELL_TOP, CELL_TOP, CELL_TOP, cgbt_pkg::FACE_LAST, CUT_TOP,
                            BID_TOP);
                queue_glyph(CELL_TOP, '0, CELL_TOP, FACE_W'(cgbt_pkg::FACE_LAST - 4), '0,
                            BID_TOP);
                queue_glyph('0, CELL_TOP, '0, '0, CUT_TOP, '0);
                queue_glyph(10'd1, 10'd2, 10'd3, FACE_W'(cgbt_pkg::FACE_LAST - 3),
                            CUT_W'(THICK), 8'h5a);
                queue_glyph(10'd512, 10'd511, 10'd0, FACE_W'(cgbt_pkg::FACE_LAST - 2),
                            CUT_W'(THICK - 1), 8'ha5);
                queue_glyph('0, '0, '0, FACE_W'(cgbt_pkg::FACE_LAST - 1), CUT_TOP, 8'h01);
                queue_glyph(CELL_TOP, CELL_TOP, CELL_TOP, FACE_TOP, CUT_TOP, BID_TOP);
                queue_glyph(CELL_TOP, CELL_TOP, CELL_TOP, FACE_W'(FACE_TOP - 1), '0, '0);
                queue_glyph(10'd77, 10'd900, 10'd300, '0, 16'h8000, 8'h80);
                // pause the stream until every triangle of the directed glyphs is back
                wait_idle();
            end
            repeat (RANDOM_PER_PHASE) queue_random_glyph();
            wait_idle();
        end

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
